// ===== sv/utf8_stream_validator_core_defines.svh =====
// Assertion macros shared by the UTF-8 stream validator RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UVC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; used by utf8v_step and utf8_stream_validator_core.
`default_nettype none

package utf8v_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 32;

    // Lead and continuation byte masks and patterns.
    localparam logic [7:0] MASK_ASCII = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LEAD  = 2'd1,
        ERR_CONT  = 2'd2,
        ERR_TRUNC = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                   is_valid;
        logic [1:0]             error_kind;
        logic [TOTAL_WIDTH-1:0] symbol_total;
    } t_out_item;

    typedef struct packed {
        logic [1:0]             pending;
        t_err                   err;
        logic [COUNT_WIDTH-1:0] count;
    } t_state;

endpackage

`default_nettype wire

// ===== sv/utf8v_step.sv =====
// Per-beat decode: classifies one byte and forms the next validator state
// and the buffer result. Depends on utf8v_pkg.
`default_nettype none

module utf8v_step
    import utf8v_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic [1:0]             lead_pending;
    logic                   lead_ok;
    logic                   is_cont;
    logic [COUNT_WIDTH-1:0] count_inc;
    t_state                 after_byte;
    t_err                   final_err;
    logic [63:0]            count_ext;

    // Continuation bytes owed after a lead byte; lead_ok low means a bad lead.
    always_comb begin
        lead_ok      = 1'b1;
        lead_pending = 2'd0;
        if ((i_item.data_byte & MASK_ASCII) == 8'h00) begin
            lead_pending = 2'd0;
        end else if ((i_item.data_byte & MASK_LEAD2) == PAT_LEAD2) begin
            lead_pending = 2'd1;
        end else if ((i_item.data_byte & MASK_LEAD3) == PAT_LEAD3) begin
            lead_pending = 2'd2;
        end else if ((i_item.data_byte & MASK_LEAD4) == PAT_LEAD4) begin
            lead_pending = 2'd3;
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign is_cont   = (i_item.data_byte & MASK_CONT) == PAT_CONT;
    assign count_inc = (i_state.count == '1) ? i_state.count
                                             : i_state.count + 1'b1;

    always_comb begin
        after_byte = i_state;
        if (i_item.byte_present && i_state.err == ERR_NONE) begin
            if (i_state.pending == 2'd0) begin
                if (!lead_ok) begin
                    after_byte.err = ERR_LEAD;
                end else if (lead_pending == 2'd0) begin
                    after_byte.count = count_inc;
                end else begin
                    after_byte.pending = lead_pending;
                end
            end else if (is_cont) begin
                after_byte.pending = i_state.pending - 2'd1;
                if (i_state.pending == 2'd1) begin
                    after_byte.count = count_inc;
                end
            end else begin
                after_byte.err = ERR_CONT;
            end
        end
    end

    always_comb begin
        final_err = after_byte.err;
        if (after_byte.err == ERR_NONE && after_byte.pending != 2'd0) begin
            final_err = ERR_TRUNC;
        end
    end

    assign count_ext = 64'(after_byte.count);

    always_comb begin
        o_result.is_valid     = (final_err == ERR_NONE);
        o_result.error_kind   = final_err;
        o_result.symbol_total = count_ext[TOTAL_WIDTH-1:0];
    end

    // The last beat of a buffer returns the state to its cleared value.
    always_comb begin
        if (i_item.last_byte) begin
            o_state.pending = 2'd0;
            o_state.err     = ERR_NONE;
            o_state.count   = '0;
        end else begin
            o_state = after_byte;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_stream_validator_core.sv =====
// UTF-8 stream validator: takes one byte beat per clock and returns one
// result beat per buffer, on the beat marked last. A beat goes into the
// input register, is decoded against the running state as it leaves it,
// and its result lands in the output register, which presents it. Sustained
// rate is one beat per cycle; input stalls only while a result waits in
// the output register and the next last beat needs it. Overlong forms and
// surrogates are not flagged.
// Depends on utf8v_pkg, utf8v_step and utf8_stream_validator_core_defines.svh.
`default_nettype none

`include "utf8_stream_validator_core_defines.svh"

module utf8_stream_validator_core
    import utf8v_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item step_result;
    logic      out_free;
    logic      advance;
    logic      load_result;

    utf8v_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Beats that produce no result never wait on the output side.
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && (!r_in.last_byte || out_free);
    assign load_result = advance && r_in.last_byte;
    assign o_in_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pending <= 2'd0;
            r_state.err     <= ERR_NONE;
            r_state.count   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UVC_ASSERT_NEXT(a_clear_after_last, load_result,
        (r_state.pending == 2'd0 && r_state.err == ERR_NONE && r_state.count == '0),
        "validator state not cleared after the last beat of a buffer")
    `UVC_ASSERT_NEXT(a_error_sticky, (r_state.err != ERR_NONE && !load_result),
        (r_state.err == $past(r_state.err)),
        "recorded error changed before the buffer ended")
    `UVC_ASSERT_NEXT(a_count_monotonic, !load_result,
        (r_state.count >= $past(r_state.count)),
        "symbol count went down inside a buffer")
    `UVC_ASSERT_SAME(a_result_kind_match, load_result,
        (step_result.is_valid == (step_result.error_kind == ERR_NONE)),
        "valid flag disagrees with error kind")

endmodule

`default_nettype wire
